// File: hw/rtl/crw_pkg.sv
package crw_pkg;

  // Status codes reported with each message result.
  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_COUNT_WRAP  = 4'd2,
    ST_TABLE_OVF   = 4'd3,
    ST_EMPTY_SEG   = 4'd4,
    ST_SEG_OVF     = 4'd5,
    ST_NOT_STRUCT  = 4'd6,
    ST_NO_DATA     = 4'd7,
    ST_OFFSET_OUT  = 4'd8
  } status_t;

  // Width of the segment table length in bytes.
  localparam int unsigned TB_W = 35;

  // Table length after reset and after each message: one segment, two words.
  localparam logic [TB_W-1:0] TB_RESET = TB_W'(8);

  // One message byte as held in the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } crw_item_t;

  // One result item as handed to the output register.
  typedef struct packed {
    status_t     status;
    logic [63:0] word;
  } crw_result_t;

  // Segment table length in bytes, padded to a whole word.
  function automatic logic [TB_W-1:0] seg_table_len(input logic [31:0] scw);
    logic [31:0] sc;
    logic [32:0] words;
    begin
      sc    = scw + 32'd1;
      words = 33'd1 + {1'b0, sc} + {32'd0, ~sc[0]};
      return {words, 2'b00};
    end
  endfunction

endpackage

// File: hw/rtl/capnp_root_word_extract_unit.sv
// Root word extractor for framed Cap'n Proto messages.
// The input channel carries one message byte per item on in_data_byte, with
// in_last_byte high on the final byte of each message. The block follows the
// segment table header, captures the root struct pointer and then the first
// data word of the root struct as the bytes stream past.
// The result channel carries one item per message, produced by its last
// byte: out_status (zero when the message is well formed) and out_mono_time,
// the captured word, which reads as zero for any other status.
// Throughput is one byte per cycle. An item is held in the input
// register; a result enters the output register as its last byte leaves
// the input register. The byte counter, the header compares and the
// target offset add all sit in the single stage between those registers.
// When the receiver stalls, the held result waits and bytes without a
// last flag keep flowing; a further last byte stops in the input register
// until the output register frees. The byte counter saturates at
// 2^LENGTH_WIDTH-1, after which no more bytes are captured.
// Synchronous reset empties both registers and clears the message context.
module capnp_root_word_extract_unit
  import crw_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [63:0] out_mono_time
);

  crw_item_t   in_item, item;
  logic        item_valid, item_take;
  logic        res_free, res_load;
  crw_result_t res, out_res;

  assign in_item.data = in_data_byte;
  assign in_item.last = in_last_byte;

  // Input register.
  crw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // Message parser and checks.
  crw_core #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_free   (res_free),
    .res_load   (res_load),
    .res        (res)
  );

  // Output register.
  crw_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status    = out_res.status;
  assign out_mono_time = out_res.word;

endmodule

// File: hw/rtl/crw_in_stage.sv
module crw_in_stage
  import crw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  crw_item_t in_item,
  output logic      item_valid,
  output crw_item_t item,
  input  logic      item_take
);

  logic      valid_r;
  crw_item_t item_r;

  // The register refills in the same cycle that its item is consumed.
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (item_take) begin
      valid_r <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: hw/rtl/crw_core.sv
module crw_core
  import crw_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  crw_item_t   item,
  output logic        item_take,
  input  logic        res_free,
  output logic        res_load,
  output crw_result_t res
);

  localparam int unsigned LW = LENGTH_WIDTH;
  localparam int unsigned AW = ((LW > 36) ? LW : 36) + 2;

  logic [LW-1:0]   cnt_r, cnt_nxt, cnt_upd;
  logic [31:0]     scw_r, scw_nxt, scw_upd;
  logic [31:0]     fsw_r, fsw_nxt, fsw_upd;
  logic [63:0]     rp_r, rp_nxt, rp_upd;
  logic [63:0]     cw_r, cw_nxt, cw_upd;
  logic [TB_W-1:0] tb_r, tb_nxt;

  logic              sat;
  logic signed [AW-1:0] p_s, tb_s, tb8_s, tgt_s, tgt8_s, r_s, s0_s, tbs0_s;
  logic              in_rp, in_tgt;
  logic [2:0]        lane;
  status_t           status;

  // A byte that causes no result moves on at once; a last byte waits for
  // room in the output register.
  assign item_take = item_valid && (!item.last || res_free);
  assign res_load  = item_take && item.last;

  // Offsets and window bounds in a signed width wide enough for all of them.
  assign sat    = (cnt_r == {LW{1'b1}});
  assign lane   = cnt_r[2:0];
  assign p_s    = signed'({{(AW-LW){1'b0}}, cnt_r});
  assign tb_s   = signed'({{(AW-TB_W){1'b0}}, tb_r});
  assign tb8_s  = tb_s + AW'(8);
  assign tgt_s  = tb8_s + signed'({{(AW-33){rp_r[31]}}, rp_r[31:2], 3'b000});
  assign tgt8_s = tgt_s + AW'(8);
  assign in_rp  = (p_s >= tb_s) && (p_s < tb8_s);
  assign in_tgt = (p_s >= tb8_s) && (tgt_s >= tb8_s) && (p_s >= tgt_s) && (p_s < tgt8_s);

  // Field capture for the current byte. The table length and all targets are
  // word aligned, so the lane is always the low three bits of the count.
  always_comb begin
    cnt_upd = cnt_r;
    scw_upd = scw_r;
    fsw_upd = fsw_r;
    rp_upd  = rp_r;
    cw_upd  = cw_r;
    if (!sat) begin
      if (cnt_r < LW'(4)) begin
        scw_upd[lane[1:0]*8 +: 8] = item.data;
      end else if (cnt_r < LW'(8)) begin
        fsw_upd[lane[1:0]*8 +: 8] = item.data;
      end
      if (in_rp) begin
        rp_upd[lane*8 +: 8] = item.data;
        // Offset of minus one points back at the root pointer itself.
        if (lane == 3'd7 && tgt_s == tb_s) begin
          cw_upd = rp_upd;
        end
      end else if (in_tgt) begin
        cw_upd[lane*8 +: 8] = item.data;
      end
      cnt_upd = cnt_r + LW'(1);
    end
  end

  // Message checks, in order of their status codes.
  assign r_s    = signed'({{(AW-LW){1'b0}}, cnt_upd});
  assign s0_s   = signed'({{(AW-35){1'b0}}, fsw_upd, 3'b000});
  assign tbs0_s = tb_s + s0_s;

  always_comb begin
    if (r_s < AW'(16)) begin
      status = ST_SHORT;
    end else if (scw_upd == 32'hFFFF_FFFF) begin
      status = ST_COUNT_WRAP;
    end else if (tb_s > r_s) begin
      status = ST_TABLE_OVF;
    end else if (fsw_upd == 32'd0) begin
      status = ST_EMPTY_SEG;
    end else if (tbs0_s > r_s) begin
      status = ST_SEG_OVF;
    end else if (rp_upd[1:0] != 2'b00) begin
      status = ST_NOT_STRUCT;
    end else if (rp_upd[47:32] == 16'd0) begin
      status = ST_NO_DATA;
    end else if ((tgt_s < tb_s) || (tgt8_s > tbs0_s)) begin
      status = ST_OFFSET_OUT;
    end else begin
      status = ST_OK;
    end
  end

  assign res.status = status;
  assign res.word   = (status == ST_OK) ? cw_upd : 64'd0;

  // Next state: a last byte clears the message context.
  always_comb begin
    cnt_nxt = cnt_r;
    scw_nxt = scw_r;
    fsw_nxt = fsw_r;
    rp_nxt  = rp_r;
    cw_nxt  = cw_r;
    tb_nxt  = tb_r;
    if (item_take) begin
      if (item.last) begin
        cnt_nxt = '0;
        scw_nxt = '0;
        fsw_nxt = '0;
        rp_nxt  = '0;
        cw_nxt  = '0;
        tb_nxt  = TB_RESET;
      end else begin
        cnt_nxt = cnt_upd;
        scw_nxt = scw_upd;
        fsw_nxt = fsw_upd;
        rp_nxt  = rp_upd;
        cw_nxt  = cw_upd;
        tb_nxt  = seg_table_len(scw_upd);
      end
    end
  end

  // Message context registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      scw_r <= '0;
      fsw_r <= '0;
      rp_r  <= '0;
      cw_r  <= '0;
      tb_r  <= TB_RESET;
    end else begin
      cnt_r <= cnt_nxt;
      scw_r <= scw_nxt;
      fsw_r <= fsw_nxt;
      rp_r  <= rp_nxt;
      cw_r  <= cw_nxt;
      tb_r  <= tb_nxt;
    end
  end

endmodule

// File: hw/rtl/crw_out_reg.sv
module crw_out_reg
  import crw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_load,
  input  crw_result_t res,
  output logic        res_free,
  output logic        out_valid,
  input  logic        out_ready,
  output crw_result_t out_res
);

  logic        valid_r;
  crw_result_t res_r;

  // A new result may enter while the held one is taken in the same cycle.
  assign res_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

endmodule

// File: tb/tb.sv
module tb;
  import crw_pkg::*;

  // The byte counter tops out at 2^32-1 with the default LENGTH_WIDTH.
  localparam longint COUNT_MAX = (longint'(1) << 32) - 1;

  // Tracks one message at a time and keeps the results still owed by the block.
  class root_word_checker;
    crw_result_t owed_results[$];
    int unsigned errors;
    longint      byte_pos;
    logic [31:0] seg_count_word;
    logic [31:0] first_seg_words;
    logic [63:0] root_ref;
    logic [63:0] target_word;

    function new();
      errors = 0;
      start_message();
    endfunction

    function void start_message();
      byte_pos        = 0;
      seg_count_word  = '0;
      first_seg_words = '0;
      root_ref        = '0;
      target_word     = '0;
    endfunction

    // Length of the segment table in bytes, padded to a whole word.
    static function longint table_len(logic [31:0] scw);
      logic [31:0] sc;
      longint      words;
      sc    = scw + 32'd1;
      words = 1 + longint'(sc) + (sc[0] ? 0 : 1);
      return words * 4;
    endfunction

    // Byte position of the word that the root pointer points at.
    static function longint target_pos(longint tb, logic [63:0] ptr);
      logic [29:0] v;
      longint      off;
      v   = ptr[31:2];
      off = longint'($signed(v));
      return tb + 8 + off * 8;
    endfunction

    // Called for every accepted input item; queues a result on a last byte.
    function void note_byte(logic [7:0] b, logic last);
      longint      p;
      longint      tb;
      longint      t;
      longint      s0;
      logic [31:0] sc;
      crw_result_t res;
      p = byte_pos;
      if (p < COUNT_MAX) begin
        tb = table_len(seg_count_word);
        if (p < 4) begin
          seg_count_word[int'(p) * 8 +: 8] = b;
        end else if (p < 8) begin
          first_seg_words[int'(p - 4) * 8 +: 8] = b;
        end
        if (p >= 8) begin
          if (p >= tb && p < tb + 8) begin
            root_ref[int'(p - tb) * 8 +: 8] = b;
            // A pointer with an offset of minus one points at itself.
            if (p == tb + 7 && target_pos(tb, root_ref) == tb) begin
              target_word = root_ref;
            end
          end else if (p >= tb + 8) begin
            t = target_pos(tb, root_ref);
            if (t >= tb + 8 && p >= t && p < t + 8) begin
              target_word[int'(p - t) * 8 +: 8] = b;
            end
          end
        end
        byte_pos = p + 1;
      end
      if (!last) return;

      // Header checks, taken in the order of the status codes.
      sc         = seg_count_word + 32'd1;
      tb         = table_len(seg_count_word);
      s0         = longint'(first_seg_words) * 8;
      res.word   = '0;
      if (byte_pos < 16) begin
        res.status = ST_SHORT;
      end else if (sc == 32'd0) begin
        res.status = ST_COUNT_WRAP;
      end else if (tb > byte_pos) begin
        res.status = ST_TABLE_OVF;
      end else if (s0 < 8) begin
        res.status = ST_EMPTY_SEG;
      end else if (tb + s0 > byte_pos) begin
        res.status = ST_SEG_OVF;
      end else if (root_ref[1:0] != 2'b00) begin
        res.status = ST_NOT_STRUCT;
      end else if (root_ref[47:32] == 16'd0) begin
        res.status = ST_NO_DATA;
      end else begin
        t = target_pos(tb, root_ref);
        if (t < tb || t + 8 > tb + s0) begin
          res.status = ST_OFFSET_OUT;
        end else begin
          res.status = ST_OK;
          res.word   = target_word;
        end
      end
      owed_results.push_back(res);
      start_message();
    endfunction

    // Called for every accepted result item.
    function void check_result(logic [3:0] st, logic [63:0] w);
      crw_result_t res;
      if (owed_results.size() == 0) begin
        $error("unexpected result: out_status %0d, out_mono_time %h", st, w);
        errors++;
        return;
      end
      res = owed_results.pop_front();
      if (st !== res.status) begin
        $error("out_status: expected %0d, actual %0d", res.status, st);
        errors++;
      end
      if (w !== res.word) begin
        $error("out_mono_time: expected %h, actual %h", res.word, w);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    function void report_leftover();
      while (owed_results.size() != 0) begin
        $error("missing result: out_status %0d expected", owed_results[0].status);
        void'(owed_results.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [3:0]  out_status;
  logic [63:0] out_mono_time;

  root_word_checker board = new();
  bit          calm       = 1'b0;
  int          sent_bytes = 0;
  int          sent_msgs  = 0;
  int          stall_left = 0;

  capnp_root_word_extract_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_mono_time (out_mono_time)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: checks each accepted result and stalls in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_status, out_mono_time);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one item, with an occasional gap in front, and waits for it to be taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b, last);
    sent_bytes++;
  endtask

  // Sends a framed message: header words, table filler, root pointer, random body.
  task automatic send_message(input logic [31:0] scw, input logic [31:0] segw,
                              input logic [63:0] ptr, input int len);
    longint     tb;
    logic [7:0] b;
    tb = root_word_checker::table_len(scw);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i < 4) begin
        b = scw[i * 8 +: 8];
      end else if (i < 8) begin
        b = segw[(i - 4) * 8 +: 8];
      end else if (i >= tb && i < tb + 8) begin
        b = ptr[int'(i - tb) * 8 +: 8];
      end
      send_byte(b, i == len - 1);
    end
    sent_msgs++;
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  // Mostly well-formed messages, with one header fault aimed at in some of them.
  task automatic send_random_message();
    int          kind;
    int          off;
    int          len;
    logic [31:0] scw;
    logic [31:0] segw;
    logic [63:0] ptr;
    longint      tb;
    kind = $urandom_range(0, 15);
    scw  = $urandom_range(0, 3);
    segw = $urandom_range(1, 4);
    off  = int'($urandom_range(0, segw)) - 1;
    ptr  = {16'($urandom), 16'($urandom_range(1, 16'hFFFF)), 30'(off), 2'b00};
    case (kind)
      1: scw = '1;
      2: scw = $urandom_range(10, 4000);
      3: segw = '0;
      5: ptr[1:0] = 2'($urandom_range(1, 3));
      6: ptr[47:32] = '0;
      7: ptr[31:2] = 30'($urandom);
      8: begin
        scw  = $urandom;
        segw = $urandom;
        ptr  = {$urandom, $urandom};
      end
      default: ;
    endcase
    tb  = root_word_checker::table_len(scw);
    len = int'(tb) + int'(segw) * 8 + int'($urandom_range(0, 3));
    case (kind)
      0: len = $urandom_range(1, 15);
      2: len = $urandom_range(16, 40);
      3: len = int'(tb) + int'($urandom_range(8, 16));
      4: len = int'(tb) + int'(segw) * 8 - int'($urandom_range(1, 8));
      8: len = $urandom_range(1, 40);
      default: ;
    endcase
    send_message(scw, segw, ptr, len);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A one-byte message of all ones, then a minimal message whose root
    // pointer points at itself with every offset and size bit set.
    send_message(32'hFF, 32'd0, 64'd0, 1);
    send_message(32'd0, 32'd1, {16'hFFFF, 16'hFFFF, 30'h3FFF_FFFF, 2'b00}, 16);
    wait_drained();

    while (sent_bytes < 1150 || sent_msgs < 40) begin
      if (sent_bytes >= 1000) calm = 1'b1;
      if (sent_msgs == 20) wait_drained();
      send_random_message();
    end

    in_valid <= 1'b0;
    for (int n = 0; n < 2000 && board.outstanding() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    board.report_leftover();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
